[src/bpli_pkg.sv]
// Package for the bad pixel line interpolator.
// Holds default sizes, register indexes and port widths; no dependencies.
`default_nettype none

package bpli_pkg;

   localparam int DEF_MAX_LINE_WIDTH = 4096;
   localparam int DEF_PIXEL_BITS     = 32;
   localparam int DEF_TIMEOUT_BITS   = 16;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam int THRESHOLD_BITS  = 32;
   localparam int TIMEOUT_REG_BITS = 16;
   localparam int LINE_WIDTH_BITS = 13;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_BAD_THRESHOLD      = 3'd0,
      REG_HORIZONTAL_TIMEOUT = 3'd1,
      REG_VERTICAL_TIMEOUT   = 3'd2,
      REG_LINE_WIDTH         = 3'd3,
      REG_FILL_DATA          = 3'd4
   } reg_index_type;

   localparam logic [THRESHOLD_BITS-1:0]   RST_BAD_THRESHOLD = '1;
   localparam logic [TIMEOUT_REG_BITS-1:0] RST_TIMEOUT       = '0;
   localparam logic [LINE_WIDTH_BITS-1:0]  RST_LINE_WIDTH    = 13'd4096;
   localparam logic                        RST_FILL_DATA     = 1'b1;

endpackage

`default_nettype wire

[src/bpli_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// Read returns the old contents when the same entry is written in that cycle.
`default_nettype none

module bpli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[src/bad_pixel_line_interpolator.sv]
// Top level of the bad pixel line interpolator.
// Depends on bpli_pkg and bpli_ram.
`default_nettype none

// Pixels stream in raster order through the accept stage and output queue to
// the result port, one pixel per clock sustained while it is not stalled; the
// three-entry output queue absorbs back-pressure. A pixel whose weight is at
// or above the threshold is replaced from its left neighbor while the row
// budget lasts, else from the pixel above while its column budget lasts. The
// previous line and the column budgets live in one line memory that is read
// when a request is accepted and written back the next cycle; a pixel that
// revisits the column just written (line width of one) takes the forwarded
// value. After reset a clearing pass zeroes the column budgets; no request is
// accepted during it, configuration writes are.
module bad_pixel_line_interpolator
   import bpli_pkg::*;
#(
   parameter int MAX_LINE_WIDTH = DEF_MAX_LINE_WIDTH,
   parameter int PIXEL_BITS     = DEF_PIXEL_BITS,
   parameter int TIMEOUT_BITS   = DEF_TIMEOUT_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // Fields from bit 0: data_in, weight_in, zero padding.
   input  wire logic [((2*PIXEL_BITS+7)/8)*8-1:0]    req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // Fields from bit 0: data_out, weight_out, zero padding.
   output logic      [((2*PIXEL_BITS+7)/8)*8-1:0]    rsp_tdata,
   output logic                                      rsp_tlast,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [CSR_ADDR_BITS-1:0]             csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0]             csr_wdata
);

   localparam int TDATA_W = ((2*PIXEL_BITS+7)/8)*8;
   localparam int CW      = $clog2(MAX_LINE_WIDTH);
   localparam int MW      = TIMEOUT_BITS + 2*PIXEL_BITS;
   localparam logic [31:0] MAX_W = 32'(MAX_LINE_WIDTH);
   localparam logic [63:0] PIX_MASK = {64{1'b1}} >> (64 - PIXEL_BITS);
   localparam int QD = 3;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] data;
      logic [PIXEL_BITS-1:0] weight;
      logic                  last;
   } out_item_type;

   // Configuration registers.
   logic [THRESHOLD_BITS-1:0]   bad_threshold_ff;
   logic [TIMEOUT_REG_BITS-1:0] horizontal_timeout_ff;
   logic [TIMEOUT_REG_BITS-1:0] vertical_timeout_ff;
   logic [LINE_WIDTH_BITS-1:0]  line_width_ff;
   logic                        fill_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bad_threshold_ff      <= RST_BAD_THRESHOLD;
         horizontal_timeout_ff <= RST_TIMEOUT;
         vertical_timeout_ff   <= RST_TIMEOUT;
         line_width_ff         <= RST_LINE_WIDTH;
         fill_data_ff          <= RST_FILL_DATA;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_addr)
            REG_BAD_THRESHOLD:      bad_threshold_ff <= csr_wdata[THRESHOLD_BITS-1:0];
            REG_HORIZONTAL_TIMEOUT: horizontal_timeout_ff <= csr_wdata[TIMEOUT_REG_BITS-1:0];
            REG_VERTICAL_TIMEOUT:   vertical_timeout_ff <= csr_wdata[TIMEOUT_REG_BITS-1:0];
            REG_LINE_WIDTH:         line_width_ff <= csr_wdata[LINE_WIDTH_BITS-1:0];
            REG_FILL_DATA:          fill_data_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Clearing pass over the line memory after reset.
   logic          clear_ff, clear_in;
   logic [CW-1:0] clear_addr_ff, clear_addr_in;

   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         if (clear_addr_ff == CW'(MAX_LINE_WIDTH - 1)) begin
            clear_in = 1'b0;
         end else begin
            clear_addr_in = clear_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // Accept stage: column position and memory read.
   logic          accept;
   logic [31:0]   lw_ext;
   logic [31:0]   width_m1_ext;
   logic [CW-1:0] width_m1;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] col_cur;
   logic          col_last;

   assign lw_ext = 32'(line_width_ff);

   always_comb begin
      if (lw_ext == 32'd0) begin
         width_m1_ext = 32'd0;
      end else if (lw_ext > MAX_W) begin
         width_m1_ext = MAX_W - 32'd1;
      end else begin
         width_m1_ext = lw_ext - 32'd1;
      end
      width_m1 = width_m1_ext[CW-1:0];
      col_cur  = (col_ff > width_m1) ? width_m1 : col_ff;
      col_last = (col_cur == width_m1);
      col_in   = col_ff;
      if (accept) begin
         col_in = col_last ? '0 : col_cur + 1'b1;
      end
   end

   logic                  s1_valid_ff;
   logic [CW-1:0]         s1_addr_ff;
   logic                  s1_first_ff;
   logic                  s1_last_ff;
   logic [PIXEL_BITS-1:0] s1_data_ff;
   logic [PIXEL_BITS-1:0] s1_weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_addr_ff   <= col_cur;
         s1_first_ff  <= (col_cur == '0);
         s1_last_ff   <= col_last;
         s1_data_ff   <= req_tdata[PIXEL_BITS-1:0];
         s1_weight_ff <= req_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
      end
   end

   // Line memory: {column budget, weight above, data above}.
   logic          mem_wr_en;
   logic [CW-1:0] mem_wr_addr;
   logic [MW-1:0] mem_wr_data;
   logic [MW-1:0] mem_rd_data;

   bpli_ram #(
      .WIDTH(MW),
      .DEPTH(MAX_LINE_WIDTH)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (accept),
      .rd_addr(col_cur),
      .rd_data(mem_rd_data)
   );

   // Last write, forwarded to a read of the same entry issued at that edge.
   logic          fwd_valid_ff;
   logic [CW-1:0] fwd_addr_ff;
   logic [MW-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= mem_wr_en;
      end
      fwd_addr_ff <= mem_wr_addr;
      fwd_data_ff <= mem_wr_data;
   end

   // Update stage.
   logic [TIMEOUT_BITS-1:0] row_budget_ff, row_budget_in;
   logic [PIXEL_BITS-1:0]   left_data_ff, left_data_in;
   logic [PIXEL_BITS-1:0]   left_weight_ff, left_weight_in;

   logic [MW-1:0]           entry;
   logic [TIMEOUT_BITS-1:0] col_budget, col_budget_new;
   logic [PIXEL_BITS-1:0]   above_data, above_weight;
   logic [TIMEOUT_BITS-1:0] row_budget;
   logic [31:0]             htmo_ext, vtmo_ext;
   logic [63:0]             thr_ext;
   logic                    is_bad;
   logic [PIXEL_BITS-1:0]   res_data, res_weight, mem_data_new;

   assign htmo_ext = 32'(horizontal_timeout_ff);
   assign vtmo_ext = 32'(vertical_timeout_ff);
   assign thr_ext  = 64'(bad_threshold_ff) & PIX_MASK;

   always_comb begin
      entry = (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) ? fwd_data_ff : mem_rd_data;
      above_data   = entry[PIXEL_BITS-1:0];
      above_weight = entry[2*PIXEL_BITS-1:PIXEL_BITS];
      col_budget   = entry[MW-1:2*PIXEL_BITS];
      row_budget   = s1_first_ff ? '0 : row_budget_ff;
      is_bad       = (64'(s1_weight_ff) >= thr_ext);

      res_data       = s1_data_ff;
      res_weight     = s1_weight_ff;
      col_budget_new = col_budget;
      row_budget_in  = row_budget;

      if (is_bad) begin
         if (row_budget == '0) begin
            if (col_budget != '0) begin
               col_budget_new = col_budget - 1'b1;
               res_weight     = above_weight;
               if (fill_data_ff) begin
                  res_data = above_data;
               end
            end
         end else begin
            row_budget_in = row_budget - 1'b1;
            res_weight    = left_weight_ff;
            if (fill_data_ff) begin
               res_data = left_data_ff;
            end
         end
      end else begin
         row_budget_in  = htmo_ext[TIMEOUT_BITS-1:0];
         col_budget_new = vtmo_ext[TIMEOUT_BITS-1:0];
      end

      mem_data_new   = fill_data_ff ? res_data : above_data;
      left_data_in   = res_data;
      left_weight_in = res_weight;

      if (clear_ff) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clear_addr_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = s1_valid_ff;
         mem_wr_addr = s1_addr_ff;
         mem_wr_data = {col_budget_new, res_weight, mem_data_new};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_budget_ff  <= '0;
         left_data_ff   <= '0;
         left_weight_ff <= '0;
      end else if (s1_valid_ff) begin
         row_budget_ff  <= row_budget_in;
         left_data_ff   <= left_data_in;
         left_weight_ff <= left_weight_in;
      end
   end

   // Output queue.
   out_item_type q_mem_ff [QD];
   logic [1:0]   q_wr_ptr_ff, q_wr_ptr_in;
   logic [1:0]   q_rd_ptr_ff, q_rd_ptr_in;
   logic [1:0]   q_count_ff, q_count_in;
   logic         q_pop;
   logic [2:0]   in_flight;
   out_item_type q_head;

   assign in_flight  = 3'(q_count_ff) + 3'(s1_valid_ff);
   assign req_tready = !clear_ff && (in_flight < 3'(QD));
   assign accept     = req_tvalid && req_tready;
   assign q_pop      = rsp_tvalid && rsp_tready;

   always_comb begin
      q_wr_ptr_in = q_wr_ptr_ff;
      q_rd_ptr_in = q_rd_ptr_ff;
      if (s1_valid_ff) begin
         q_wr_ptr_in = (q_wr_ptr_ff == 2'(QD - 1)) ? '0 : q_wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         q_rd_ptr_in = (q_rd_ptr_ff == 2'(QD - 1)) ? '0 : q_rd_ptr_ff + 1'b1;
      end
      q_count_in = q_count_ff + 2'(s1_valid_ff) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ptr_ff <= '0;
         q_rd_ptr_ff <= '0;
         q_count_ff  <= '0;
      end else begin
         q_wr_ptr_ff <= q_wr_ptr_in;
         q_rd_ptr_ff <= q_rd_ptr_in;
         q_count_ff  <= q_count_in;
      end
      if (s1_valid_ff) begin
         q_mem_ff[q_wr_ptr_ff] <= '{data: res_data, weight: res_weight, last: s1_last_ff};
      end
   end

   assign q_head     = q_mem_ff[q_rd_ptr_ff];
   assign rsp_tvalid = (q_count_ff != '0);
   assign rsp_tdata  = TDATA_W'({q_head.weight, q_head.data});
   assign rsp_tlast  = q_head.last;

endmodule

`default_nettype wire

[src/bpli_checker.sv]
// Port-level checker for the bad pixel line interpolator, bound to the top level.
// Depends on bpli_pkg for the configuration port widths.
`default_nettype none

module bpli_checker
   import bpli_pkg::*;
#(
   parameter int DATA_BITS = 64
) (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tvalid,
   input wire logic                     req_tready,
   input wire logic [DATA_BITS-1:0]     req_tdata,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [DATA_BITS-1:0]     rsp_tdata,
   input wire logic                     rsp_tlast,
   input wire logic                     csr_valid,
   input wire logic                     csr_ready,
   input wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // The line memory is being cleared right after reset.
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("request taken or response shown right after reset");

   // Every accepted request passes the accept stage and is queued for output.
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("accepted request produced no response");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // Configuration writes are taken even while the memory is cleared.
   a_csr_always_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid && !req_tready |-> csr_ready)
      else $error("configuration write refused");

   // Offered requests and register writes carry known values.
   a_inputs_known: assert property (@(posedge clock) disable iff (reset)
      !(req_tvalid && $isunknown(req_tdata)) &&
      !(csr_valid && $isunknown({csr_addr, csr_wdata})))
      else $error("unknown value offered on an input channel");

endmodule

bind bad_pixel_line_interpolator bpli_checker #(
   .DATA_BITS(TDATA_W)
) u_bpli_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tdata (req_tdata),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_addr  (csr_addr),
   .csr_wdata (csr_wdata)
);

`default_nettype wire
